// ===== hdl/jbhc_pkg.sv =====
// ----------------------------------------------------------------------------
// jbhc_pkg
// shared types, status codes and marker constants for the jpeg header checker
// ----------------------------------------------------------------------------
package jbhc_pkg;

  // verdict codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_NONE        = 2'd0;  // no verdict held

  // marker and field constants
  localparam logic [7:0] MK_FILL     = 8'hFF;
  localparam logic [7:0] MK_SOI      = 8'hD8;
  localparam logic [7:0] MK_EOI      = 8'hD9;
  localparam logic [7:0] MK_SOF0     = 8'hC0;
  localparam logic [7:0] MK_SOS      = 8'hDA;
  localparam logic [7:0] MK_RST_LO   = 8'hD0;
  localparam logic [7:0] MK_RST_HI   = 8'hD7;
  localparam logic [7:0] SAMP_LUMA   = 8'h22;
  localparam logic [7:0] SAMP_CHROMA = 8'h11;
  localparam logic [7:0] PRECISION   = 8'd8;
  localparam logic [7:0] NUM_COMP    = 8'd3;
  localparam logic [2:0] ALL_COMP    = 3'h7;
  localparam logic [15:0] SOF0_LEN   = 16'd17;
  localparam logic [15:0] MIN_LEN    = 16'd2;
  localparam logic [15:0] MIN_SOS_LEN = 16'd6;
  localparam logic [2:0] MIN_BYTES   = 3'd4;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } out_item_t;

  // a byte with its precomputed marker class
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_fill;
    logic       is_soi;
    logic       is_eoi;
    logic       is_sof0;
    logic       is_sos;
    logic       is_bad;       // 00, 01, rst, soi, eoi
    logic       is_other_sof; // non-baseline frame markers
    logic       is_comp_id;   // value 1 to 3
  } class_t;

endpackage

// ===== hdl/jbhc_front.sv =====
// ----------------------------------------------------------------------------
// jbhc_front
// classifies each incoming byte against the marker codes
// ----------------------------------------------------------------------------
module jbhc_front (
  input  jbhc_pkg::in_item_t item,
  output jbhc_pkg::class_t   cls
);
  import jbhc_pkg::*;

  logic [7:0] b;
  logic       rst_code;
  logic       other_sof;

  assign b = item.data_byte;
  assign rst_code = (b >= MK_RST_LO) && (b <= MK_RST_HI);
  // C1-C3, C5-C7, C9-CB, CD-CF: upper nibble C, nonzero and not a multiple of four
  assign other_sof = (b[7:4] == 4'hC) && (b[1:0] != 2'd0);

  always_comb begin
    cls.data_byte    = b;
    cls.last_byte    = item.last_byte;
    cls.is_fill      = (b == MK_FILL);
    cls.is_soi       = (b == MK_SOI);
    cls.is_eoi       = (b == MK_EOI);
    cls.is_sof0      = (b == MK_SOF0);
    cls.is_sos       = (b == MK_SOS);
    cls.is_bad       = (b == 8'h00) || (b == 8'h01) || (b == MK_SOI) ||
                       (b == MK_EOI) || rst_code;
    cls.is_other_sof = other_sof;
    cls.is_comp_id   = (b >= 8'd1) && (b <= 8'd3);
  end

endmodule

// ===== hdl/jbhc_queue.sv =====
// ----------------------------------------------------------------------------
// jbhc_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module jbhc_queue #(
  parameter int DEPTH = jbhc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jbhc_pkg::class_t push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output jbhc_pkg::class_t pop_data
);
  import jbhc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  class_t          slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign not_full  = (count_r != FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == FULL_CNT) |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");
`endif

endmodule

// ===== hdl/jbhc_back.sv =====
// ----------------------------------------------------------------------------
// jbhc_back
// marker segment walker and frame header checks, with the result register
// ----------------------------------------------------------------------------
module jbhc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  jbhc_pkg::class_t    q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output jbhc_pkg::out_item_t out_data
);
  import jbhc_pkg::*;

  typedef enum logic [2:0] {
    PH_SOI0, PH_SOI1, PH_MARK, PH_FILL, PH_LENH, PH_LENL, PH_BODY, PH_SCAN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] seg_len_r, seg_len_nxt;
  logic [15:0] seg_pos_r, seg_pos_nxt;
  logic        cur_sof0_r, cur_sof0_nxt;
  logic        cur_sos_r, cur_sos_nxt;
  logic        frame_seen_r, frame_seen_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        decided_r, decided_nxt;
  logic [1:0]  final_r, final_nxt;
  logic [2:0]  mask_r, mask_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        prev_ff_r, prev_ff_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;
  logic        luma_r, luma_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] pos_inc;
  logic [2:0]  id_bit;
  logic [7:0]  want_samp;
  logic        finish;
  logic [1:0]  status;

  assign b         = q_data.data_byte;
  assign q_pop     = q_valid && (!q_data.last_byte || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign len       = {seg_len_r[15:8], b};
  assign pos_inc   = seg_pos_r + 16'd1;
  assign want_samp = luma_r ? SAMP_LUMA : SAMP_CHROMA;

  always_comb begin
    unique case (b[1:0])
      2'd1:    id_bit = 3'b001;
      2'd2:    id_bit = 3'b010;
      default: id_bit = 3'b100;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    seg_len_nxt    = seg_len_r;
    seg_pos_nxt    = seg_pos_r;
    cur_sof0_nxt   = cur_sof0_r;
    cur_sos_nxt    = cur_sos_r;
    frame_seen_nxt = frame_seen_r;
    held_nxt       = held_r;
    decided_nxt    = decided_r;
    final_nxt      = final_r;
    mask_nxt       = mask_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    prev_ff_nxt    = prev_ff_r;
    byte_cnt_nxt   = byte_cnt_r;
    luma_nxt       = luma_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    finish         = 1'b0;
    status         = ST_INVALID;

    if (q_pop) begin
      if (!decided_r) begin
        unique case (phase_r)
          PH_SOI0: begin
            if (!q_data.is_fill) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_INVALID;
            end else begin
              phase_nxt = PH_SOI1;
            end
          end
          PH_SOI1: begin
            if (!q_data.is_soi) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_INVALID;
            end else begin
              phase_nxt = PH_MARK;
            end
          end
          PH_MARK: begin
            if (!q_data.is_fill) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_INVALID;
            end else begin
              phase_nxt = PH_FILL;
            end
          end
          PH_FILL: begin
            // fill bytes keep waiting for the marker code
            if (q_data.is_fill) begin
              phase_nxt = PH_FILL;
            end else if (q_data.is_bad) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_INVALID;
            end else if (q_data.is_other_sof) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_UNSUPPORTED;
            end else begin
              cur_sof0_nxt = q_data.is_sof0;
              cur_sos_nxt  = q_data.is_sos;
              held_nxt     = ST_NONE;
              seg_pos_nxt  = '0;
              phase_nxt    = PH_LENH;
            end
          end
          PH_LENH: begin
            seg_len_nxt = {b, 8'h00};
            phase_nxt   = PH_LENL;
          end
          PH_LENL: begin
            seg_len_nxt = len;
            if (len < MIN_LEN) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_INVALID;
            end else begin
              mask_nxt = '0;
              luma_nxt = 1'b0;
              if (cur_sof0_r) begin
                if (frame_seen_r) begin
                  held_nxt = ST_INVALID;
                end else if (len != SOF0_LEN) begin
                  held_nxt = ST_UNSUPPORTED;
                end
              end else if (cur_sos_r) begin
                if (!frame_seen_r || len < MIN_SOS_LEN) begin
                  held_nxt = ST_INVALID;
                end
              end
              seg_pos_nxt = MIN_LEN;
              if (len == MIN_LEN) begin
                finish = 1'b1;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            if (cur_sof0_r && held_r == ST_NONE) begin
              priority case (seg_pos_r)
                16'd2: if (b != PRECISION) held_nxt = ST_UNSUPPORTED;
                16'd3: height_nxt = {b, 8'h00};
                16'd4: height_nxt = {height_r[15:8], b};
                16'd5: width_nxt = {b, 8'h00};
                16'd6: width_nxt = {width_r[15:8], b};
                16'd7: if (b != NUM_COMP) held_nxt = ST_UNSUPPORTED;
                16'd8, 16'd11, 16'd14: begin
                  // component id: 1 to 3, each once
                  if (!q_data.is_comp_id || (mask_r & id_bit) != 3'b000) begin
                    held_nxt = ST_UNSUPPORTED;
                  end else begin
                    mask_nxt = mask_r | id_bit;
                    luma_nxt = (b == 8'd1);
                  end
                end
                16'd9, 16'd12, 16'd15: begin
                  if (b != want_samp) held_nxt = ST_UNSUPPORTED;
                end
                default: held_nxt = held_r;
              endcase
            end
            seg_pos_nxt = pos_inc;
            if (pos_inc >= seg_len_r) begin
              finish = 1'b1;
            end
          end
          PH_SCAN: begin
            if (prev_ff_r && q_data.is_eoi) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_OK;
            end
            prev_ff_nxt = q_data.is_fill;
          end
          default: begin
            decided_nxt = 1'b1;
            final_nxt   = ST_INVALID;
          end
        endcase

        // segment end: held verdict or sof0 checks decide, else accepted
        if (finish) begin
          if (held_nxt != ST_NONE) begin
            decided_nxt = 1'b1;
            final_nxt   = held_nxt;
          end else if (cur_sof0_r) begin
            if (mask_nxt != ALL_COMP) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_UNSUPPORTED;
            end else if (width_nxt == '0 || height_nxt == '0) begin
              decided_nxt = 1'b1;
              final_nxt   = ST_INVALID;
            end else begin
              frame_seen_nxt = 1'b1;
              phase_nxt      = PH_MARK;
            end
          end else if (cur_sos_r) begin
            prev_ff_nxt = 1'b0;
            phase_nxt   = PH_SCAN;
          end else begin
            phase_nxt = PH_MARK;
          end
        end
      end

      if (byte_cnt_r < MIN_BYTES) begin
        byte_cnt_nxt = byte_cnt_r + 3'd1;
      end

      if (q_data.last_byte) begin
        status = decided_nxt ? final_nxt : ST_INVALID;
        if (byte_cnt_nxt < MIN_BYTES) begin
          status = ST_INVALID;
        end
        out_valid_nxt             = 1'b1;
        out_data_nxt.status       = status;
        out_data_nxt.frame_width  = (status == ST_OK) ? width_nxt : '0;
        out_data_nxt.frame_height = (status == ST_OK) ? height_nxt : '0;
        // next byte starts a new file
        phase_nxt      = PH_SOI0;
        seg_len_nxt    = '0;
        seg_pos_nxt    = '0;
        cur_sof0_nxt   = 1'b0;
        cur_sos_nxt    = 1'b0;
        frame_seen_nxt = 1'b0;
        held_nxt       = ST_NONE;
        decided_nxt    = 1'b0;
        final_nxt      = ST_OK;
        mask_nxt       = '0;
        width_nxt      = '0;
        height_nxt     = '0;
        prev_ff_nxt    = 1'b0;
        byte_cnt_nxt   = '0;
        luma_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SOI0;
      seg_len_r    <= '0;
      seg_pos_r    <= '0;
      cur_sof0_r   <= 1'b0;
      cur_sos_r    <= 1'b0;
      frame_seen_r <= 1'b0;
      held_r       <= ST_NONE;
      decided_r    <= 1'b0;
      final_r      <= ST_OK;
      mask_r       <= '0;
      width_r      <= '0;
      height_r     <= '0;
      prev_ff_r    <= 1'b0;
      byte_cnt_r   <= '0;
      luma_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      seg_len_r    <= seg_len_nxt;
      seg_pos_r    <= seg_pos_nxt;
      cur_sof0_r   <= cur_sof0_nxt;
      cur_sos_r    <= cur_sos_nxt;
      frame_seen_r <= frame_seen_nxt;
      held_r       <= held_nxt;
      decided_r    <= decided_nxt;
      final_r      <= final_nxt;
      mask_r       <= mask_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      prev_ff_r    <= prev_ff_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      luma_r       <= luma_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.last_byte) |=>
      (out_valid_r && !decided_r && phase_r == PH_SOI0 && byte_cnt_r == '0))
    else $error("last byte did not produce a result and restart");
  a_frame_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    frame_seen_r |-> (width_r != '0 && height_r != '0))
    else $error("frame header accepted with zero size");
  a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY && !decided_r) |-> (seg_pos_r < seg_len_r))
    else $error("segment position past segment length");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status != 2'd3))
    else $error("reserved status code on result");
`endif

endmodule

// ===== hdl/jpeg_baseline_header_checker_unit.sv =====
// an accepted last byte is queued; once the back pops it, its verdict is registered
// throughput: one byte per cycle, set by the one-byte-per-cycle segment walker in the back
// a waiting verdict stalls only the next last byte; the two-entry queue then fills and
//   in_ready drops until out_ready frees the result register
// reset: rst_n low at a rising edge (synchronous) empties the queue, drops out_valid
//   and returns the parser to the start-of-image check; no clearing pass is needed
// ----------------------------------------------------------------------------
// jpeg_baseline_header_checker_unit
// byte-stream checker for baseline jpeg headers: one verdict per file
// ----------------------------------------------------------------------------
module jpeg_baseline_header_checker_unit #(
  parameter int QUEUE_DEPTH = jbhc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // byte input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  jbhc_pkg::in_item_t  in_data,
  // verdict channel
  output logic                out_valid,
  input  logic                out_ready,
  output jbhc_pkg::out_item_t out_data
);
  import jbhc_pkg::*;

  class_t front_cls;   // classified input byte
  class_t q_head;      // oldest queued byte
  logic   q_not_full;
  logic   q_not_empty;
  logic   q_pop;
  logic   in_xfer;     // input transfer this cycle

  // front: marker classification, no state
  jbhc_front u_front (
    .item (in_data),
    .cls  (front_cls)
  );

  assign in_ready = q_not_full;
  assign in_xfer  = in_valid && in_ready;

  // queue decouples input acceptance from the parser and result stall
  jbhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (front_cls),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_head)
  );

  // back: segment walker; holds a last byte only while the result register is busy
  jbhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> q_not_empty)
    else $error("input stalled with an empty queue");
  a_result_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> $past(q_pop))
    else $error("result appeared without a byte being processed");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (q_not_empty && !out_valid) |-> q_pop)
    else $error("back stalled with a free result register");
`endif

endmodule
